[hw/rtl/rsas_pkg.sv]
// ----------------------------------------------------------------------------
// rsas_pkg
// Shared constants and types for the rotated sorted array search block.
// ----------------------------------------------------------------------------
package rsas_pkg;

  localparam int RSAS_DEPTH      = 1024;
  localparam int RSAS_DATA_WIDTH = 32;
  localparam int CMD_W           = 2;
  localparam int POS_W           = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_EVAL,
    ST_FINISH
  } state_t;

endpackage

[hw/rtl/rsas_if.sv]
// ----------------------------------------------------------------------------
// rsas_if
// Valid/ready channels for command words and search result words.
// ----------------------------------------------------------------------------
interface rsas_in_if #(
  parameter int DATA_WIDTH = rsas_pkg::RSAS_DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic [rsas_pkg::CMD_W-1:0]   cmd;
  logic signed [DATA_WIDTH-1:0] data_value;

  modport source (output valid, output cmd, output data_value, input ready);
  modport sink   (input valid, input cmd, input data_value, output ready);
endinterface

interface rsas_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [rsas_pkg::POS_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

[hw/rtl/rotated_sorted_array_search.sv]
// ----------------------------------------------------------------------------
// rotated_sorted_array_search
// Holds signed words in RAM; clear, append and binary search in a rotated run.
// ----------------------------------------------------------------------------
//  channel  dir  fields                 word
//  in_ch    in   cmd, data_value        clear / append / search command
//  out_ch   out  found, position        one per search
//
//  Clear and append complete in the idle state. A search runs P probes (at
//  most floor(log2(count)) + 1), each an issue step that sends the mid, left
//  and right reads to the two RAM copies and an eval step on the registered
//  data; a miss ends with one more issue step on the empty window.
//  Reset clears the count, FSM and output valid; RAM contents are kept.
//  The output register holds a result until taken; a finished search waits
//  for it, with in_ch.ready low, before returning to idle.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search #(
  parameter int DEPTH      = rsas_pkg::RSAS_DEPTH,
  parameter int DATA_WIDTH = rsas_pkg::RSAS_DATA_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  rsas_in_if.sink     in_ch,
  rsas_out_if.source  out_ch
);
  import rsas_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t state, state_next;

  logic [CW-1:0]                count;
  logic [CW-1:0]                lo;
  logic [CW-1:0]                hip;      // one past the upper bound
  logic [IW-1:0]                mid_q;
  logic signed [DATA_WIDTH-1:0] tgt;
  logic                         res_found;

  logic                         out_valid;
  logic                         out_found;
  logic [POS_W-1:0]             out_pos;

  logic                         in_acc;
  logic                         out_free;
  logic                         in_range;
  logic [CW-1:0]                mid_w;
  logic [CW-1:0]                hi_w;
  logic                         wr_en;

  logic signed [DATA_WIDTH-1:0] vm, vl, vr;
  logic                         hit;
  logic                         go_left;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign in_range = lo < hip;
  assign mid_w    = lo + ((hip - lo - CW'(1)) >> 1);
  assign hi_w     = hip - CW'(1);

  rsas_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_ml (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (count[IW-1:0]),
    .wr_data   (in_ch.data_value),
    .rd_addr_a (mid_w[IW-1:0]),
    .rd_data_a (vm),
    .rd_addr_b (lo[IW-1:0]),
    .rd_data_b (vl)
  );

  rsas_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_r (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (count[IW-1:0]),
    .wr_data   (in_ch.data_value),
    .rd_addr_a (hi_w[IW-1:0]),
    .rd_data_a (vr),
    .rd_addr_b (hi_w[IW-1:0]),
    .rd_data_b ()
  );

  // probe decision
  always_comb begin
    hit = (vm == tgt);
    if (vl <= vm) begin
      go_left = (vl <= tgt) && (tgt < vm);
    end else begin
      go_left = !((vm < tgt) && (tgt <= vr));
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && in_ch.cmd == CMD_SEARCH) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        state_next = in_range ? ST_EVAL : ST_FINISH;
      end
      ST_EVAL: begin
        state_next = hit ? ST_FINISH : ST_ISSUE;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    wr_en       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        wr_en       = in_acc && in_ch.cmd == CMD_APPEND && count < CW'(DEPTH);
      end
      default: begin
        in_ch.ready = 1'b0;
        wr_en       = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_ch.cmd)
              CMD_CLEAR:  count <= '0;
              CMD_APPEND: if (wr_en) count <= count + CW'(1);
              CMD_SEARCH: begin
                tgt <= in_ch.data_value;
                lo  <= '0;
                hip <= count;
              end
              default: ;
            endcase
          end
        end
        ST_ISSUE: begin
          mid_q     <= mid_w[IW-1:0];
          res_found <= 1'b0;
        end
        ST_EVAL: begin
          if (hit) begin
            res_found <= 1'b1;
          end else if (go_left) begin
            hip <= CW'(mid_q);
          end else begin
            lo <= CW'(mid_q) + CW'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_found <= res_found;
            out_pos   <= res_found ? POS_W'(mid_q) : '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.found    = out_found;
  assign out_ch.position = out_pos;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count beyond depth");

  a_mid_in_window: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |-> (CW'(mid_q) >= lo) && (CW'(mid_q) < hip))
    else $error("probe index outside search window");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result word raised outside finish");

endmodule

[hw/rtl/rsas_ram.sv]
// ----------------------------------------------------------------------------
// rsas_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rsas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
